// File: rtl/tans_enc_pkg.sv
`default_nettype none

package tans_enc_pkg;

    // Field widths of the stream transactions.
    localparam int OPCODE_W  = 2;
    localparam int SYM_W     = 8;
    localparam int FREQ_W    = 12;
    localparam int START_W   = 11;
    localparam int BYTE_W    = 8;
    localparam int TAIL_W    = 4;
    localparam int FS_W      = 12;

    // Packed bus widths; the input tdata bus is padded to whole bytes.
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = OPCODE_W;
    localparam int M_TDATA_W = BYTE_W + TAIL_W + FS_W;
    localparam int M_TUSER_W = 2;

    // Bit buffer holds one byte; a shift into a full buffer flushes it.
    localparam logic [TAIL_W-1:0] BUF_FULL = TAIL_W'(BYTE_W);

    // Input operation codes.
    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FINISH = 2'd2
    } opcode_t;

    // Result kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TAIL = 1'b1;

    // Control from the sequencer to the bit buffer.
    typedef struct packed {
        logic shift;
        logic din;
        logic clear;
    } bb_ctl_t;

    // Status of the bit buffer.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [TAIL_W-1:0] count;
    } bb_stat_t;

endpackage

`default_nettype wire

// File: rtl/tans_symbol_encoder.sv
`default_nettype none

// Table-based ANS encoder with stream ports. Load transactions (opcode 0) write a
// symbol's frequency and slot start into an internal table. Encode transactions
// (opcode 1) shift k bits out of the coder state (at most LOG_L): after the
// accepting cycle come the table read, one bit of state reduction per cycle
// through the bit buffer (held while a flushed byte waits for the output), the
// state update and the handover of the last byte. A symbol with zero frequency
// skips the reduction. While the output register is stalled, a second flushed
// byte and the final handover wait. Finish transactions (opcode 2) produce one
// tail record. Each encode yields zero, one or two byte results, with tlast on
// the final one; a symbol with zero frequency yields a single result flagged as
// an error. The table has no reset; encoding a symbol that was never loaded
// gives unspecified results.
module tans_symbol_encoder #(
    parameter int LOG_L       = 11,
    parameter int NUM_SYMBOLS = 256
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Input stream.
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata: symbol[7:0], sym_freq[19:8], slot_start[30:20], zero pad [31].
    input  wire logic [tans_enc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: opcode[1:0].
    input  wire logic [tans_enc_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    // Output stream.
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // tdata: out_byte[7:0], tail_bits[11:8], final_state[23:12].
    output logic      [tans_enc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // tuser: kind[0], error[1].
    output logic      [tans_enc_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    output logic                                     m_axis_tlast
);
    import tans_enc_pkg::*;

    localparam int ST_W  = LOG_L + 1;
    localparam int AW    = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int CW    = (ST_W > FREQ_W + 1) ? ST_W : FREQ_W + 1;
    localparam int SUM_W = CW + 1;
    localparam logic [ST_W-1:0] L_VAL = ST_W'(1) << LOG_L;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOKUP = 4'b0010,
        S_SHIFT  = 4'b0100,
        S_FINAL  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [ST_W-1:0]    coder_reg, coder_next;
    logic [ST_W-1:0]    red_reg, red_next;
    logic [FREQ_W-1:0]  freq_reg, freq_next;
    logic [START_W-1:0] start_reg, start_next;
    logic               inrange_reg, inrange_next;

    // One result held back until it is known whether it is the last.
    logic               pend_valid_reg, pend_valid_next;
    logic               pend_kind_reg, pend_kind_next;
    logic [BYTE_W-1:0]  pend_byte_reg, pend_byte_next;
    logic [TAIL_W-1:0]  pend_tail_reg, pend_tail_next;
    logic [FS_W-1:0]    pend_fs_reg, pend_fs_next;
    logic               pend_err_reg, pend_err_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic               out_kind_reg, out_kind_next;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic [TAIL_W-1:0]  out_tail_reg, out_tail_next;
    logic [FS_W-1:0]    out_fs_reg, out_fs_next;
    logic               out_err_reg, out_err_next;
    logic               out_last_reg, out_last_next;

    logic [SYM_W-1:0]   in_symbol;
    logic [FREQ_W-1:0]  in_freq;
    logic [START_W-1:0] in_start;
    opcode_t            in_op;
    logic               in_acc;
    logic               in_range;
    logic               out_free;

    logic [FREQ_W-1:0]  rd_freq;
    logic [START_W-1:0] rd_start;
    logic [FREQ_W-1:0]  eff_freq;
    logic               red_ge;
    logic [SUM_W-1:0]   next_sum;

    bb_ctl_t            bb_ctl;
    bb_stat_t           bb_stat;

    // Input unpacking.
    assign in_symbol = s_axis_tdata[SYM_W-1:0];
    assign in_freq   = s_axis_tdata[SYM_W+FREQ_W-1:SYM_W];
    assign in_start  = s_axis_tdata[SYM_W+FREQ_W+START_W-1:SYM_W+FREQ_W];
    assign in_op     = opcode_t'(s_axis_tuser);
    assign in_range  = {1'b0, in_symbol} < (SYM_W+1)'(NUM_SYMBOLS);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Symbol table.
    tans_enc_table #(
        .DEPTH (NUM_SYMBOLS),
        .AW    (AW)
    ) u_table (
        .clk      (clk),
        .wr_en    (in_acc && (in_op == OP_LOAD) && in_range),
        .wr_addr  (in_symbol[AW-1:0]),
        .wr_freq  (in_freq),
        .wr_start (in_start),
        .rd_en    (in_acc && (in_op == OP_ENCODE)),
        .rd_addr  (in_symbol[AW-1:0]),
        .rd_freq  (rd_freq),
        .rd_start (rd_start)
    );

    // Bit buffer fed one bit per cycle while reducing, unless a flush waits on the output.
    tans_enc_bitbuf u_bitbuf (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (bb_ctl),
        .stat  (bb_stat)
    );

    // Out-of-range symbols encode as zero frequency.
    assign eff_freq = inrange_reg ? rd_freq : '0;

    // Reduction continues while the state is at least twice the frequency.
    assign red_ge = CW'(red_reg) >= CW'({freq_reg, 1'b0});

    // Next coder state, wrapping at the state width.
    assign next_sum = SUM_W'(L_VAL) + SUM_W'(start_reg) + SUM_W'(red_reg)
                    - SUM_W'(freq_reg);

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        coder_next      = coder_reg;
        red_next        = red_reg;
        freq_next       = freq_reg;
        start_next      = start_reg;
        inrange_next    = inrange_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_byte_next  = pend_byte_reg;
        pend_tail_next  = pend_tail_reg;
        pend_fs_next    = pend_fs_reg;
        pend_err_next   = pend_err_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_kind_next   = out_kind_reg;
        out_byte_next   = out_byte_reg;
        out_tail_next   = out_tail_reg;
        out_fs_next     = out_fs_reg;
        out_err_next    = out_err_reg;
        out_last_next   = out_last_reg;
        bb_ctl          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (in_op)
                        OP_ENCODE:
                        begin
                            inrange_next = in_range;
                            state_next   = S_LOOKUP;
                        end
                        OP_FINISH:
                        begin
                            pend_valid_next = 1'b1;
                            pend_kind_next  = KIND_TAIL;
                            pend_byte_next  = bb_stat.data;
                            pend_tail_next  = bb_stat.count;
                            pend_fs_next    = FS_W'(coder_reg);
                            pend_err_next   = 1'b0;
                            coder_next      = '1;
                            bb_ctl.clear    = 1'b1;
                            state_next      = S_FINAL;
                        end
                        default:
                        begin
                            // Loads go straight to the table; other codes are dropped.
                        end
                    endcase
                end
            end

            S_LOOKUP:
            begin
                freq_next  = eff_freq;
                start_next = rd_start;
                red_next   = coder_reg;
                if (eff_freq == '0)
                begin
                    pend_valid_next = 1'b1;
                    pend_kind_next  = KIND_BYTE;
                    pend_byte_next  = '0;
                    pend_tail_next  = '0;
                    pend_fs_next    = '0;
                    pend_err_next   = 1'b1;
                    state_next      = S_FINAL;
                end
                else
                begin
                    state_next = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                if (red_ge)
                begin
                    if (bb_stat.count == BUF_FULL)
                    begin
                        // This shift flushes a byte; an earlier one moves out first.
                        if (!pend_valid_reg || out_free)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_kind_next  = pend_kind_reg;
                                out_byte_next  = pend_byte_reg;
                                out_tail_next  = pend_tail_reg;
                                out_fs_next    = pend_fs_reg;
                                out_err_next   = pend_err_reg;
                                out_last_next  = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_kind_next  = KIND_BYTE;
                            pend_byte_next  = bb_stat.data;
                            pend_tail_next  = '0;
                            pend_fs_next    = '0;
                            pend_err_next   = 1'b0;
                            bb_ctl.shift    = 1'b1;
                            bb_ctl.din      = red_reg[0];
                            red_next        = red_reg >> 1;
                        end
                    end
                    else
                    begin
                        bb_ctl.shift = 1'b1;
                        bb_ctl.din   = red_reg[0];
                        red_next     = red_reg >> 1;
                    end
                end
                else
                begin
                    coder_next = next_sum[ST_W-1:0];
                    state_next = S_FINAL;
                end
            end

            S_FINAL:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = pend_kind_reg;
                    out_byte_next   = pend_byte_reg;
                    out_tail_next   = pend_tail_reg;
                    out_fs_next     = pend_fs_reg;
                    out_err_next    = pend_err_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            coder_reg      <= '1;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            coder_reg      <= coder_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        red_reg       <= red_next;
        freq_reg      <= freq_next;
        start_reg     <= start_next;
        inrange_reg   <= inrange_next;
        pend_kind_reg <= pend_kind_next;
        pend_byte_reg <= pend_byte_next;
        pend_tail_reg <= pend_tail_next;
        pend_fs_reg   <= pend_fs_next;
        pend_err_reg  <= pend_err_next;
        out_kind_reg  <= out_kind_next;
        out_byte_reg  <= out_byte_next;
        out_tail_reg  <= out_tail_next;
        out_fs_reg    <= out_fs_next;
        out_err_reg   <= out_err_next;
        out_last_reg  <= out_last_next;
    end

    // Output packing.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_fs_reg, out_tail_reg, out_byte_reg};
    assign m_axis_tuser  = {out_err_reg, out_kind_reg};
    assign m_axis_tlast  = out_last_reg;

    // No result may be held back once the sequencer is idle.
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("pending result left behind in idle");

    // The bit buffer never holds more than one byte.
    a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bb_stat.count <= BUF_FULL)
        else $error("bit buffer count overflow");

    // A finish restarts the coder and empties the bit buffer.
    a_finish_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_op == OP_FINISH)) |=> ((coder_reg == '1) && (bb_stat.count == '0)))
        else $error("finish did not restart the coder");

    // A flush that displaces a held byte only happens when the output can take it.
    a_flush_room: assert property (@(posedge clk) disable iff (!rst_n)
        (bb_ctl.shift && (bb_stat.count == BUF_FULL) && pend_valid_reg) |-> out_free)
        else $error("flushed byte would overwrite a stalled result");

endmodule

`default_nettype wire

// File: rtl/tans_enc_table.sv
`default_nettype none

module tans_enc_table #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic                            clk,
    input  wire logic                            wr_en,
    input  wire logic [AW-1:0]                   wr_addr,
    input  wire logic [tans_enc_pkg::FREQ_W-1:0]  wr_freq,
    input  wire logic [tans_enc_pkg::START_W-1:0] wr_start,
    input  wire logic                            rd_en,
    input  wire logic [AW-1:0]                   rd_addr,
    output logic      [tans_enc_pkg::FREQ_W-1:0]  rd_freq,
    output logic      [tans_enc_pkg::START_W-1:0] rd_start
);
    import tans_enc_pkg::*;

    localparam int ENTRY_W = FREQ_W + START_W;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    // Single write port for table loads.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_start, wr_freq};
        end
    end

    // Registered read port for symbol lookups.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_freq  = rd_data_reg[FREQ_W-1:0];
    assign rd_start = rd_data_reg[ENTRY_W-1:FREQ_W];

endmodule

`default_nettype wire

// File: rtl/tans_enc_bitbuf.sv
`default_nettype none

module tans_enc_bitbuf (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire tans_enc_pkg::bb_ctl_t  ctl,
    output tans_enc_pkg::bb_stat_t      stat
);
    import tans_enc_pkg::*;

    logic [BYTE_W-1:0] data_reg, data_next;
    logic [TAIL_W-1:0] count_reg, count_next;

    // One bit enters at the bottom per shift. Shifting into a full buffer
    // hands the whole byte out (the caller samples it first) and restarts
    // with the new bit alone, so bits above the count are always zero.
    always_comb
    begin
        data_next  = data_reg;
        count_next = count_reg;
        if (ctl.clear)
        begin
            data_next  = '0;
            count_next = '0;
        end
        else if (ctl.shift)
        begin
            if (count_reg == BUF_FULL)
            begin
                data_next  = {{(BYTE_W-1){1'b0}}, ctl.din};
                count_next = TAIL_W'(1);
            end
            else
            begin
                data_next  = {data_reg[BYTE_W-2:0], ctl.din};
                count_next = count_reg + TAIL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            data_reg  <= data_next;
            count_reg <= count_next;
        end
    end

    assign stat.data  = data_reg;
    assign stat.count = count_reg;

endmodule

`default_nettype wire

// File: verif/tb.sv
`default_nettype none

module tb;

    import tans_enc_pkg::*;

    localparam int          LOG_L      = 11;
    localparam int          TANS_L     = 1 << LOG_L;
    localparam int unsigned RUN_LIMIT  = 400000;
    localparam int unsigned RAND_ITEMS = 1500;

    // The block ignores this opcode; it is sent as noise.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    // One output transaction, split into its fields.
    typedef struct {
        logic              kind;
        logic [BYTE_W-1:0] out_byte;
        logic [TAIL_W-1:0] tail_bits;
        logic [FS_W-1:0]   final_state;
        logic              error;
        logic              last;
    } tans_record_t;

    // Coder model: keeps the symbol table, the coder state and the bit
    // buffer, and queues the records that each input transaction produces.
    class tans_checker;
        logic [FREQ_W-1:0]  freq_tab [256];
        logic [START_W-1:0] start_tab [256];
        logic [FS_W-1:0]    coder_state;
        int unsigned        bit_buf;
        int unsigned        bit_cnt;
        tans_record_t       expected_q [$];
        int unsigned        mismatches;

        function new();
            foreach (freq_tab[i])
            begin
                freq_tab[i]  = '0;
                start_tab[i] = '0;
            end
            restart();
            mismatches = 0;
        endfunction

        function void restart();
            coder_state = FS_W'(2 * TANS_L - 1);
            bit_buf     = 0;
            bit_cnt     = 0;
        endfunction

        function void push_record(logic kind, logic [BYTE_W-1:0] data,
                                  logic [TAIL_W-1:0] tbits, logic [FS_W-1:0] fstate,
                                  logic err, logic last);
            tans_record_t rec;
            rec.kind        = kind;
            rec.out_byte    = data;
            rec.tail_bits   = tbits;
            rec.final_state = fstate;
            rec.error       = err;
            rec.last        = last;
            expected_q.insert(expected_q.size(), rec);
        endfunction

        function void note_item(logic [OPCODE_W-1:0] op, logic [SYM_W-1:0] sym,
                                logic [FREQ_W-1:0] freq, logic [START_W-1:0] base);
            int unsigned       f;
            int unsigned       reduced;
            int unsigned       shifted;
            int unsigned       nshift;
            int unsigned       nbytes;
            logic [BYTE_W-1:0] flushed [2];
            case (op)
                OP_LOAD:
                begin
                    freq_tab[sym]  = freq;
                    start_tab[sym] = base;
                end
                OP_ENCODE:
                begin
                    f = freq_tab[sym];
                    if (f == 0)
                    begin
                        // An absent symbol leaves the coder untouched.
                        push_record(KIND_BYTE, '0, '0, '0, 1'b1, 1'b1);
                    end
                    else
                    begin
                        // Shift low state bits out until the state fits the slot.
                        reduced = coder_state;
                        shifted = 0;
                        nshift  = 0;
                        while (reduced >= 2 * f)
                        begin
                            shifted = (shifted << 1) | (reduced & 1);
                            nshift++;
                            reduced >>= 1;
                        end
                        bit_buf = (bit_buf << nshift) | shifted;
                        bit_cnt += nshift;
                        // Flush whole bytes, oldest bits first.
                        nbytes = 0;
                        while (bit_cnt > 8 && nbytes < 2)
                        begin
                            flushed[nbytes] = BYTE_W'(bit_buf >> (bit_cnt - 8));
                            bit_cnt -= 8;
                            bit_buf &= (1 << bit_cnt) - 1;
                            nbytes++;
                        end
                        for (int k = 0; k < nbytes; k++)
                            push_record(KIND_BYTE, flushed[k], '0, '0, 1'b0,
                                        k == nbytes - 1);
                        coder_state = FS_W'(TANS_L + start_tab[sym] + reduced - f);
                    end
                end
                OP_FINISH:
                begin
                    push_record(KIND_TAIL, BYTE_W'(bit_buf), TAIL_W'(bit_cnt),
                                coder_state, 1'b0, 1'b1);
                    restart();
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_field(string name, int unsigned want, int unsigned seen);
            if (want != seen)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, seen);
                mismatches++;
            end
        endfunction

        function void compare_record(tans_record_t got);
            tans_record_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected record: kind %0d out_byte %0d last %0d",
                       got.kind, got.out_byte, got.last);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("out_byte", want.out_byte, got.out_byte);
            check_field("tail_bits", want.tail_bits, got.tail_bits);
            check_field("final_state", want.final_state, got.final_state);
            check_field("error", want.error, got.error);
            check_field("last", want.last, got.last);
        endfunction
    endclass

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 m_axis_tlast;

    tans_checker          coder_model = new();
    int unsigned          src_idle_pct;
    int unsigned          sink_idle_pct;
    int unsigned          cycle_count = 0;
    bit                   loaded [256];
    logic [SYM_W-1:0]     loaded_list [$];

    tans_symbol_encoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock generation.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run-away guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Output side back-pressure.
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Output monitor: the transaction completes at the next rising edge.
    always @(negedge clk)
    begin
        tans_record_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.out_byte    = m_axis_tdata[7:0];
            got.tail_bits   = m_axis_tdata[11:8];
            got.final_state = m_axis_tdata[23:12];
            got.kind        = m_axis_tuser[0];
            got.error       = m_axis_tuser[1];
            got.last        = m_axis_tlast;
            coder_model.compare_record(got);
        end
    end

    // Drive one input transaction; returns at the edge where it is accepted.
    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [SYM_W-1:0] sym,
                             input logic [FREQ_W-1:0] freq,
                             input logic [START_W-1:0] base);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        // tdata: symbol[7:0], sym_freq[19:8], slot_start[30:20], zero pad [31].
        s_axis_tdata  <= {1'b0, base, freq, sym};
        // tuser: opcode[1:0].
        s_axis_tuser  <= op;
        do
            @(negedge clk);
        while (!s_axis_tready);
        @(posedge clk);
        coder_model.note_item(op, sym, freq, base);
        if (op == OP_LOAD && !loaded[sym])
        begin
            loaded[sym] = 1'b1;
            loaded_list.insert(loaded_list.size(), sym);
        end
    endtask

    initial
    begin
        int unsigned      rand_items;
        int unsigned      n_alpha;
        int unsigned      n_enc;
        int unsigned      remaining;
        int unsigned      cap;
        int unsigned      f;
        int unsigned      base;
        logic [SYM_W-1:0] sym;
        logic [SYM_W-1:0] alpha [$];
        bit               in_alpha [256];

        rand_items    = 0;
        src_idle_pct  = 13;
        sink_idle_pct = 88;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        // Finish on a fresh coder: empty tail with the initial state.
        send_item(OP_FINISH, 8'hFF, 12'hFFF, 11'h7FF);
        send_item(OP_LOAD, 8'h00, 12'd1, 11'd0);
        send_item(OP_LOAD, 8'hFF, 12'd2048, 11'd0);
        send_item(OP_LOAD, 8'h55, 12'd0, 11'd2047);
        send_item(OP_LOAD, 8'hAA, 12'd1024, 11'd1024);
        send_item(OP_LOAD, 8'hF0, 12'd2047, 11'd1);
        // Smallest frequency pushes LOG_L bits out of the state.
        send_item(OP_ENCODE, 8'h00, 12'h000, 11'h000);
        // Full-range frequency shifts nothing out.
        send_item(OP_ENCODE, 8'hFF, 12'hFFF, 11'h7FF);
        // Absent symbol flags an error.
        send_item(OP_ENCODE, 8'h55, 12'h000, 11'h000);
        send_item(OP_ENCODE, 8'h00, 12'h000, 11'h000);
        // Buffer overflows by two bytes here.
        send_item(OP_ENCODE, 8'h00, 12'h000, 11'h000);
        send_item(OP_ENCODE, 8'hAA, 12'h000, 11'h000);
        send_item(OP_ENCODE, 8'hF0, 12'h000, 11'h000);
        send_item(OP_UNUSED, 8'h3C, 12'hABC, 11'h555);
        send_item(OP_FINISH, 8'h00, 12'h000, 11'h000);
        send_item(OP_FINISH, 8'h00, 12'h000, 11'h000);
        // Slot runs past L; from the initial state the next state still fits without wrapping.
        send_item(OP_LOAD, 8'h80, 12'd3, 11'd2047);
        send_item(OP_ENCODE, 8'h80, 12'h000, 11'h000);
        send_item(OP_ENCODE, 8'h80, 12'h000, 11'h000);
        send_item(OP_ENCODE, 8'h80, 12'h000, 11'h000);
        // State below the frequency.
        send_item(OP_LOAD, 8'h01, 12'd2048, 11'd2047);
        send_item(OP_ENCODE, 8'h01, 12'h000, 11'h000);
        send_item(OP_ENCODE, 8'h01, 12'h000, 11'h000);
        send_item(OP_FINISH, 8'h00, 12'h000, 11'h000);

        // Random part: mostly complete frames over a consistent table.
        while (rand_items < RAND_ITEMS)
        begin
            case (rand_items / (RAND_ITEMS / 3))
                0:
                begin
                    src_idle_pct  = 13;
                    sink_idle_pct = 88;
                end
                1:
                begin
                    src_idle_pct  = 88;
                    sink_idle_pct = 13;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase

            if ($urandom_range(99) < 70)
            begin
                // Load a fresh alphabet whose frequencies sum to L.
                if (alpha.size() == 0 || $urandom_range(99) < 75)
                begin
                    alpha.delete();
                    foreach (in_alpha[i])
                        in_alpha[i] = 1'b0;
                    n_alpha = ($urandom_range(99) < 10) ? $urandom_range(64, 1)
                                                         : $urandom_range(8, 1);
                    remaining = TANS_L;
                    base      = 0;
                    for (int i = 0; i < n_alpha; i++)
                    begin
                        do
                            sym = SYM_W'($urandom_range(255));
                        while (in_alpha[sym]);
                        in_alpha[sym] = 1'b1;
                        if (i == n_alpha - 1)
                            f = remaining;
                        else
                        begin
                            cap = 2 * remaining / (n_alpha - i);
                            if (cap > remaining - (n_alpha - 1 - i))
                                cap = remaining - (n_alpha - 1 - i);
                            f = $urandom_range(cap, 1);
                        end
                        send_item(OP_LOAD, sym, FREQ_W'(f), START_W'(base));
                        alpha.insert(alpha.size(), sym);
                        remaining -= f;
                        base      += f;
                        rand_items++;
                    end
                end
                // Encode a run of symbols from the alphabet.
                n_enc = $urandom_range(40, 4);
                repeat (n_enc)
                begin
                    send_item(OP_ENCODE, alpha[$urandom_range(alpha.size() - 1)],
                              FREQ_W'($urandom), START_W'($urandom));
                    rand_items++;
                end
                if ($urandom_range(99) < 85)
                begin
                    send_item(OP_FINISH, SYM_W'($urandom), FREQ_W'($urandom),
                              START_W'($urandom));
                    rand_items++;
                end
            end
            else
            begin
                // Noise: stray loads, encodes, finishes and ignored opcodes.
                repeat ($urandom_range(4, 1))
                begin
                    case ($urandom_range(3))
                        0:
                        begin
                            send_item(OP_LOAD, SYM_W'($urandom_range(255)),
                                      FREQ_W'($urandom_range(2048)),
                                      START_W'($urandom_range(2047)));
                            rand_items++;
                        end
                        1:
                        begin
                            send_item(OP_ENCODE,
                                      loaded_list[$urandom_range(loaded_list.size() - 1)],
                                      FREQ_W'($urandom), START_W'($urandom));
                            rand_items++;
                        end
                        2:
                        begin
                            send_item(OP_UNUSED, SYM_W'($urandom), FREQ_W'($urandom),
                                      START_W'($urandom));
                        end
                        default:
                        begin
                            send_item(OP_FINISH, SYM_W'($urandom), FREQ_W'($urandom),
                                      START_W'($urandom));
                            rand_items++;
                        end
                    endcase
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain outstanding records, then allow time for stray output.
        while (coder_model.expected_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (coder_model.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/tans_enc_pkg.sv
rtl/tans_enc_table.sv
rtl/tans_enc_bitbuf.sv
rtl/tans_symbol_encoder.sv
verif/tb.sv
